@@ design/engine_temp_alarm_beeper_core_macros.svh @@
// Assertion macros for the engine temperature alarm beeper.
// Included by the design files that carry concurrent assertions.
`ifndef ENGINE_TEMP_ALARM_BEEPER_CORE_MACROS_SVH
`define ENGINE_TEMP_ALARM_BEEPER_CORE_MACROS_SVH

// Checked on every rising edge of clk_i, ignored while rst_ni is low.
`define ETAB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form, same clocking and reset.
`define ETAB_ASSERT_IMP(label, ante, cons, msg) \
  `ETAB_ASSERT(label, (ante) |-> (cons), msg)

`endif

@@ design/etab_pkg.sv @@
// Shared types, codes and constants of the engine temperature alarm beeper.
// No dependencies; imported by etab_seq and the top level.
package etab_pkg;

  // grades
  localparam logic [1:0] GRADE_NORMAL = 2'd0;
  localparam logic [1:0] GRADE_WARN   = 2'd1;
  localparam logic [1:0] GRADE_ALARM  = 2'd2;

  // alarm codes
  localparam logic [2:0] CODE_NONE          = 3'd0;
  localparam logic [2:0] CODE_COOLANT_WARN  = 3'd1;
  localparam logic [2:0] CODE_OIL_WARN      = 3'd2;
  localparam logic [2:0] CODE_COOLANT_ALARM = 3'd3;
  localparam logic [2:0] CODE_OIL_ALARM     = 3'd4;

  // register indexes
  localparam logic [2:0] REG_COOLANT_WARN  = 3'd0;
  localparam logic [2:0] REG_COOLANT_ALARM = 3'd1;
  localparam logic [2:0] REG_OIL_WARN      = 3'd2;
  localparam logic [2:0] REG_OIL_ALARM     = 3'd3;
  localparam logic [2:0] REG_INTAKE_HIGH   = 3'd4;
  localparam logic [2:0] REG_COOLANT_TONE  = 3'd5;
  localparam logic [2:0] REG_OIL_TONE      = 3'd6;

  // register reset values
  localparam logic signed [8:0] RST_COOLANT_WARN  = 9'sd115;
  localparam logic signed [8:0] RST_COOLANT_ALARM = 9'sd130;
  localparam logic signed [8:0] RST_OIL_WARN      = 9'sd110;
  localparam logic signed [8:0] RST_OIL_ALARM     = 9'sd120;
  localparam logic signed [8:0] RST_INTAKE_HIGH   = 9'sd50;
  localparam logic [11:0]       RST_COOLANT_TONE  = 12'd1000;
  localparam logic [11:0]       RST_OIL_TONE      = 12'd1900;

  // sequencer timing in ticks
  localparam logic [7:0] TICKS_IDLE      = 8'd11;
  localparam logic [7:0] TICKS_WARN      = 8'd18;
  localparam logic [7:0] TICKS_WARN_TONE = 8'd7;
  localparam logic [7:0] TICKS_ALARM     = 8'd151;
  localparam logic [7:0] TICKS_LONG      = 8'd10;
  localparam logic [2:0] WARN_BEEPS      = 3'd4;

  typedef struct packed {
    logic [1:0] coolant;
    logic [1:0] oil;
  } grades_t;

  typedef struct packed {
    logic        tone_on;
    logic [11:0] tone_hz;
    logic [2:0]  alarm_code;
  } seq_out_t;

  function automatic logic [1:0] grade_temp(logic signed [8:0] t,
                                            logic signed [8:0] warn,
                                            logic signed [8:0] alarm);
    logic [1:0] g;
    if (t < warn) begin
      g = GRADE_NORMAL;
    end else if (t < alarm) begin
      g = GRADE_WARN;
    end else begin
      g = GRADE_ALARM;
    end
    return g;
  endfunction

endpackage

@@ design/etab_seq.sv @@
// Alarm code update and beeper sequencer, advanced one tick per enable.
// Depends on etab_pkg and the assertion macros header.
`include "engine_temp_alarm_beeper_core_macros.svh"

module etab_seq
  import etab_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  grades_t     grades_i,
  input  logic [11:0] coolant_tone_i,
  input  logic [11:0] oil_tone_i,
  output seq_out_t    res_o
);

  logic [2:0] alarm_state_q, alarm_state_d;
  logic [2:0] last_code_q, last_code_d;
  logic [2:0] beep_count_q, beep_count_d;
  logic [2:0] cycle_code_q, cycle_code_d;
  logic [7:0] cycle_pos_q, cycle_pos_d;

  logic [2:0] st_c, st_o;
  logic       is_warn, is_alarm, tone_on;
  logic [7:0] cycle_len;
  logic [8:0] pos_inc;

  always_comb begin
    // coolant first
    st_c = alarm_state_q;
    if (grades_i.coolant == GRADE_NORMAL) begin
      if (st_c == CODE_COOLANT_ALARM) st_c = CODE_NONE;
    end else if (grades_i.coolant == GRADE_WARN) begin
      if (st_c == CODE_NONE) st_c = CODE_COOLANT_WARN;
      if (st_c == CODE_COOLANT_ALARM) st_c = CODE_NONE;
    end else begin
      if (st_c != CODE_OIL_ALARM) st_c = CODE_COOLANT_ALARM;
    end
    // then oil; an oil alarm always wins
    st_o = st_c;
    if (grades_i.oil == GRADE_NORMAL) begin
      if (st_o == CODE_OIL_ALARM) st_o = CODE_NONE;
    end else if (grades_i.oil == GRADE_WARN) begin
      if (st_o == CODE_NONE || st_o == CODE_COOLANT_WARN) st_o = CODE_OIL_WARN;
      if (st_o == CODE_OIL_ALARM) st_o = CODE_NONE;
    end else begin
      st_o = CODE_OIL_ALARM;
    end
    alarm_state_d = st_o;

    // latch the code at cycle start
    cycle_code_d = cycle_code_q;
    last_code_d  = last_code_q;
    beep_count_d = beep_count_q;
    if (cycle_pos_q == 8'd0) begin
      cycle_code_d = st_o;
      if (st_o == CODE_COOLANT_WARN || st_o == CODE_OIL_WARN) begin
        if (st_o != last_code_q) begin
          beep_count_d = 3'd0;
          last_code_d  = st_o;
        end
      end else if (st_o == CODE_COOLANT_ALARM || st_o == CODE_OIL_ALARM) begin
        beep_count_d = 3'd0;
        last_code_d  = st_o;
      end
    end

    is_warn  = (cycle_code_d == CODE_COOLANT_WARN) || (cycle_code_d == CODE_OIL_WARN);
    is_alarm = (cycle_code_d == CODE_COOLANT_ALARM) || (cycle_code_d == CODE_OIL_ALARM);
    pos_inc  = {1'b0, cycle_pos_q} + 9'd1;
    tone_on  = 1'b0;
    cycle_len = TICKS_IDLE;
    if (is_warn) begin
      if (beep_count_d < WARN_BEEPS) begin
        cycle_len = TICKS_WARN;
        tone_on   = (cycle_pos_q >= 8'd1) && (cycle_pos_q <= TICKS_WARN_TONE);
        if (pos_inc >= {1'b0, TICKS_WARN}) beep_count_d = beep_count_d + 3'd1;
      end
    end else if (is_alarm) begin
      cycle_len = TICKS_ALARM;
      // three long beeps, the first two each followed by an equal gap
      tone_on = ((cycle_pos_q >= 8'd1) && (cycle_pos_q <= TICKS_LONG)) ||
                ((cycle_pos_q >= 8'd21) && (cycle_pos_q <= 8'd30)) ||
                ((cycle_pos_q >= 8'd41) && (cycle_pos_q <= 8'd50));
    end

    cycle_pos_d = (pos_inc >= {1'b0, cycle_len}) ? 8'd0 : pos_inc[7:0];

    res_o.tone_on    = tone_on;
    res_o.alarm_code = st_o;
    if (!tone_on) begin
      res_o.tone_hz = 12'd0;
    end else if (cycle_code_d == CODE_COOLANT_WARN || cycle_code_d == CODE_COOLANT_ALARM) begin
      res_o.tone_hz = coolant_tone_i;
    end else begin
      res_o.tone_hz = oil_tone_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_state_q <= CODE_NONE;
      last_code_q   <= CODE_NONE;
      beep_count_q  <= 3'd0;
      cycle_code_q  <= CODE_NONE;
      cycle_pos_q   <= 8'd0;
    end else if (adv_i) begin
      alarm_state_q <= alarm_state_d;
      last_code_q   <= last_code_d;
      beep_count_q  <= beep_count_d;
      cycle_code_q  <= cycle_code_d;
      cycle_pos_q   <= cycle_pos_d;
    end
  end

  `ETAB_ASSERT(a_pos_range, cycle_pos_q < TICKS_ALARM, "cycle position past alarm cycle")
  `ETAB_ASSERT(a_beep_sat, beep_count_q <= WARN_BEEPS, "beep count past saturation")
  `ETAB_ASSERT_IMP(a_pos_idle, cycle_code_q == CODE_NONE, cycle_pos_q < TICKS_IDLE,
                   "idle cycle ran too long")

endmodule

@@ design/engine_temp_alarm_beeper_core.sv @@
// Engine temperature alarm beeper, top level: ports, registers, grading.
// Depends on etab_pkg, etab_seq and the assertion macros header.
//
// Each input transfer is one 10 ms tick carrying coolant, oil and intake air
// temperatures; each produces exactly one result transfer with the tone
// state, alarm code and grades. The block takes one tick per clock cycle
// when the output side keeps up; a tick passes an input register and then a
// result register. Thresholds and tones sit in APB registers at byte address
// 4*index; the user must write them only while no tick is in flight, as the
// block itself does not enforce it. No clearing pass after reset.
`include "engine_temp_alarm_beeper_core_macros.svh"

module engine_temp_alarm_beeper_core
  import etab_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [8:0] coolant_temp, [17:9] oil_temp, [26:18] air_temp, [31:27] zero
  input  logic [31:0] s_axis_tdata,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] tone_on, [12:1] tone_hz, [15:13] alarm_code, [17:16] coolant_grade,
  // [19:18] oil_grade, [20] intake_high, [23:21] zero
  output logic [23:0] m_axis_tdata
);

  // configuration registers
  logic signed [8:0] cool_warn_q, cool_alarm_q, oil_warn_q, oil_alarm_q, intake_lvl_q;
  logic [11:0]       cool_tone_q, oil_tone_q;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cool_warn_q  <= RST_COOLANT_WARN;
      cool_alarm_q <= RST_COOLANT_ALARM;
      oil_warn_q   <= RST_OIL_WARN;
      oil_alarm_q  <= RST_OIL_ALARM;
      intake_lvl_q <= RST_INTAKE_HIGH;
      cool_tone_q  <= RST_COOLANT_TONE;
      oil_tone_q   <= RST_OIL_TONE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COOLANT_WARN:  cool_warn_q  <= pwdata[8:0];
        REG_COOLANT_ALARM: cool_alarm_q <= pwdata[8:0];
        REG_OIL_WARN:      oil_warn_q   <= pwdata[8:0];
        REG_OIL_ALARM:     oil_alarm_q  <= pwdata[8:0];
        REG_INTAKE_HIGH:   intake_lvl_q <= pwdata[8:0];
        REG_COOLANT_TONE:  cool_tone_q  <= pwdata[11:0];
        REG_OIL_TONE:      oil_tone_q   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_COOLANT_WARN:  prdata = {23'd0, cool_warn_q};
      REG_COOLANT_ALARM: prdata = {23'd0, cool_alarm_q};
      REG_OIL_WARN:      prdata = {23'd0, oil_warn_q};
      REG_OIL_ALARM:     prdata = {23'd0, oil_alarm_q};
      REG_INTAKE_HIGH:   prdata = {23'd0, intake_lvl_q};
      REG_COOLANT_TONE:  prdata = {20'd0, cool_tone_q};
      REG_OIL_TONE:      prdata = {20'd0, oil_tone_q};
      default:           prdata = 32'd0;
    endcase
  end

  // input register
  logic              in_valid_q, out_valid_q, adv, s_fire;
  logic signed [8:0] cool_t_q, oil_t_q, air_t_q;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cool_t_q <= s_axis_tdata[8:0];
      oil_t_q  <= s_axis_tdata[17:9];
      air_t_q  <= s_axis_tdata[26:18];
    end
  end

  // grading
  grades_t  grades;
  logic     intake_high;
  seq_out_t seq_res;

  assign grades.coolant = grade_temp(cool_t_q, cool_warn_q, cool_alarm_q);
  assign grades.oil     = grade_temp(oil_t_q, oil_warn_q, oil_alarm_q);
  assign intake_high    = (air_t_q >= intake_lvl_q);

  etab_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .grades_i       (grades),
    .coolant_tone_i (cool_tone_q),
    .oil_tone_i     (oil_tone_q),
    .res_o          (seq_res)
  );

  // result register
  seq_out_t res_q;
  grades_t  grades_q;
  logic     intake_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q         <= seq_res;
      grades_q      <= grades;
      intake_high_q <= intake_high;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, intake_high_q, grades_q.oil, grades_q.coolant,
                          res_q.alarm_code, res_q.tone_hz, res_q.tone_on};

  `ETAB_ASSERT_IMP(a_silent_hz, out_valid_q && !res_q.tone_on, res_q.tone_hz == 12'd0,
                   "tone frequency set while silent")
  `ETAB_ASSERT_IMP(a_oil_wins, out_valid_q && grades_q.oil == GRADE_ALARM,
                   res_q.alarm_code == CODE_OIL_ALARM, "oil alarm did not win")
  // a clearing oil alarm also clears a coolant alarm that it had masked
  `ETAB_ASSERT_IMP(a_cool_alarm, out_valid_q && grades_q.coolant == GRADE_ALARM,
                   res_q.alarm_code == CODE_COOLANT_ALARM ||
                   res_q.alarm_code == CODE_OIL_ALARM ||
                   res_q.alarm_code == CODE_NONE, "coolant alarm lost")

endmodule
